### hdl/solar_grid_heater_relay_control_macros.svh
// Assertion macros for the solar and grid heater relay control block.
// Uses the clk_i and rst_ni names of the module that expands them.
`ifndef SOLAR_GRID_HEATER_RELAY_CONTROL_MACROS_SVH
`define SOLAR_GRID_HEATER_RELAY_CONTROL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define SGHRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset
`define SGHRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SGHRC_ASSERT_IMP(lbl, ante, cons, msg)
`define SGHRC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/sghrc_pkg.sv
// Shared types, codes and constants of the heater relay control block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sghrc_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Depth of the queue between front and back
  localparam int unsigned SGHRC_QUEUE_DEPTH = 2;

  // Fixed thresholds
  localparam logic [9:0]  TEMP_FAULT       = 10'd990;
  localparam logic [11:0] DARK_VOLTS       = 12'd20;
  localparam logic [2:0]  DARK_LIMIT       = 3'd5;
  localparam logic [2:0]  DARK_MAX         = 3'd7;
  localparam logic [1:0]  GRID_BAD_LIMIT   = 2'd3;
  localparam logic [7:0]  SWITCH_ERR_VOLTS = 8'd10;
  localparam logic [7:0]  SWITCH_ON_VOLTS  = 8'd40;
  localparam logic [12:0] EARTH_ON_VOLTS   = 13'd50;
  localparam logic [7:0]  CMD_ENABLE_MAX   = 8'd3;
  localparam logic [7:0]  CMD_TARGET_MIN   = 8'd5;
  localparam logic [7:0]  CMD_TARGET_MAX   = 8'd67;
  localparam logic [15:0] OFF_COUNT_MAX    = 16'hFFFF;

  // State reset values
  localparam logic [9:0] PREV_TEMP_RST    = 10'd0;
  localparam logic [9:0] PREV2_TEMP_RST   = 10'd990;
  localparam logic [6:0] TARGET_RST       = 7'd5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PV_OFF_TEMP     = 3'd0,
    CFG_PV_ON_TEMP      = 3'd1,
    CFG_PV_MIN_VOLTS    = 3'd2,
    CFG_REST_CYCLES     = 3'd3,
    CFG_GRID_LOW_VOLTS  = 3'd4,
    CFG_GRID_HIGH_VOLTS = 3'd5,
    CFG_ISOLATION_LIMIT = 3'd6,
    CFG_GRID_HYSTERESIS = 3'd7
  } cfg_idx_e;

  // PV sequence request
  typedef enum logic [1:0] {
    SEQ_NONE = 2'd0,
    SEQ_ON   = 2'd1,
    SEQ_OFF  = 2'd2
  } seq_e;

  // Prioritized status
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_ISOLATION = 3'd1,
    STATUS_SENSOR    = 3'd2,
    STATUS_SWITCH    = 3'd3,
    STATUS_GRID      = 3'd4
  } status_e;

  // Command class decided by the front
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_ENABLE = 2'd1,
    CMD_TARGET = 2'd2
  } cmd_kind_e;

  // Configuration register file
  typedef struct packed {
    logic [9:0]  pv_off_temp;
    logic [9:0]  pv_on_temp;
    logic [11:0] pv_min_volts;
    logic [15:0] rest_cycles;
    logic [11:0] grid_low_volts;
    logic [11:0] grid_high_volts;
    logic [12:0] isolation_limit;
    logic [6:0]  grid_hysteresis;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pv_off_temp:     10'd770,
    pv_on_temp:      10'd740,
    pv_min_volts:    12'd1150,
    rest_cycles:     16'd100,
    grid_low_volts:  12'd1750,
    grid_high_volts: 12'd2650,
    isolation_limit: 13'd120,
    grid_hysteresis: 7'd30
  };

  // Classified measurement request handed from front to back
  typedef struct packed {
    logic [9:0] temp;         // clamped temperature, tenths
    logic       sensor_err;
    logic       dark;         // PV below darkness level
    logic       grid_out;     // grid voltage outside window
    logic       isol_err;
    logic       switch_err;   // neutral switch voltage too low
    logic       line_low;     // line switch voltage too low
    logic       line_high;    // line switch voltage high enough to start
    logic       pv_start_ok;  // PV volts, earth and neutral allow a start
    cmd_kind_e  cmd_kind;
    logic [6:0] cmd_val;
  } item_t;

endpackage

`default_nettype wire

### hdl/sghrc_front.sv
// Front stage: classifies one measurement request against the configuration.
// Depends on sghrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sghrc_front
  import sghrc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_valid_i,
  input  wire logic [7:0]         cmd_byte_i,
  input  wire logic [11:0]        pv_volts_i,
  input  wire logic [11:0]        grid_volts_i,
  input  wire logic signed [11:0] water_temp_i,
  input  wire logic [12:0]        earth_volts_i,
  input  wire logic [7:0]         line_switch_volts_i,
  input  wire logic [7:0]         neutral_switch_volts_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output item_t                   push_item_o
);

  logic  valid_q;
  item_t item_q;
  item_t item_d;
  logic  temp_bad;

  // Classify the incoming request
  always_comb begin
    temp_bad = water_temp_i[11] || ($unsigned(water_temp_i) >= {2'b00, TEMP_FAULT});
    item_d.temp        = temp_bad ? TEMP_FAULT : water_temp_i[9:0];
    item_d.sensor_err  = temp_bad;
    item_d.dark        = pv_volts_i < DARK_VOLTS;
    item_d.grid_out    = (grid_volts_i < cfg_i.grid_low_volts) ||
                         (grid_volts_i > cfg_i.grid_high_volts);
    item_d.isol_err    = earth_volts_i > cfg_i.isolation_limit;
    item_d.switch_err  = neutral_switch_volts_i < SWITCH_ERR_VOLTS;
    item_d.line_low    = line_switch_volts_i < SWITCH_ERR_VOLTS;
    item_d.line_high   = line_switch_volts_i > SWITCH_ON_VOLTS;
    item_d.pv_start_ok = (pv_volts_i > cfg_i.pv_min_volts) &&
                         (earth_volts_i < EARTH_ON_VOLTS) &&
                         (neutral_switch_volts_i > SWITCH_ON_VOLTS);
    item_d.cmd_val     = cmd_byte_i[6:0];
    if (!cmd_valid_i) begin
      item_d.cmd_kind = CMD_NONE;
    end else if (cmd_byte_i <= CMD_ENABLE_MAX) begin
      item_d.cmd_kind = CMD_ENABLE;
    end else if ((cmd_byte_i >= CMD_TARGET_MIN) && (cmd_byte_i <= CMD_TARGET_MAX)) begin
      item_d.cmd_kind = CMD_TARGET;
    end else begin
      item_d.cmd_kind = CMD_NONE;
    end
  end

  // Accept while the stage is empty or drains into the queue
  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  // Hold the classified request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

### hdl/sghrc_fifo.sv
// Short queue of classified requests between front and back.
// Depends on sghrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sghrc_fifo
  import sghrc_pkg::*;
#(
  parameter int unsigned Depth = SGHRC_QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != Full;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### hdl/sghrc_back.sv
// Back stage: applies the hysteresis rules, updates the control state and
// holds the result in an output register. Depends on sghrc_pkg and the macros.
`timescale 1ns / 1ps
`default_nettype none

`include "solar_grid_heater_relay_control_macros.svh"

module sghrc_back
  import sghrc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  wire item_t pop_item_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic       grid_relay_o,
  output logic       pv_relay_o,
  output logic [1:0] pv_sequence_o,
  output logic [2:0] status_o,
  output logic       pv_enabled_o,
  output logic       grid_enabled_o,
  output logic [6:0] grid_target_o
);

  // Control state
  logic [9:0]  prev_temp_q, prev2_temp_q;
  logic [2:0]  dark_q, dark_d;
  logic [1:0]  bad_grid_q, bad_grid_d;
  logic [15:0] pv_off_q, pv_off_d, grid_off_q, grid_off_d;
  logic        pv_relay_q, pv_relay_d, grid_relay_q, grid_relay_d;
  logic        pv_en_q, pv_en_d, grid_en_q, grid_en_d;
  logic [6:0]  target_q, target_d;

  // Output register
  logic        out_valid_q;
  seq_e        seq_q, seq_d;
  status_e     status_q, status_d;

  // Decision terms
  logic        pop;
  logic        grid_err;
  logic [15:0] pv_seen, grid_seen;
  logic        pv_hot, pv_cold, grid_hot, grid_cold;
  logic [9:0]  grid_hi;
  logic signed [11:0] grid_lo;
  item_t       it;

  assign it          = pop_item_i;
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  // Next state and result for the request at the head of the queue
  always_comb begin
    dark_d = it.dark ? ((dark_q == DARK_MAX) ? dark_q : dark_q + 1'b1) : '0;
    if (it.grid_out) begin
      bad_grid_d = (bad_grid_q == GRID_BAD_LIMIT) ? bad_grid_q : bad_grid_q + 1'b1;
    end else begin
      bad_grid_d = '0;
    end
    grid_err = bad_grid_d == GRID_BAD_LIMIT;

    // Off counts as seen this cycle, then advanced with saturation
    pv_seen    = pv_relay_q ? '0 : pv_off_q;
    grid_seen  = grid_relay_q ? '0 : grid_off_q;
    pv_off_d   = (pv_seen == OFF_COUNT_MAX) ? pv_seen : pv_seen + 1'b1;
    grid_off_d = (grid_seen == OFF_COUNT_MAX) ? grid_seen : grid_seen + 1'b1;

    // Status by priority
    if (it.isol_err) begin
      status_d = STATUS_ISOLATION;
    end else if (it.sensor_err) begin
      status_d = STATUS_SENSOR;
    end else if (it.switch_err) begin
      status_d = STATUS_SWITCH;
    end else if (grid_err) begin
      status_d = STATUS_GRID;
    end else begin
      status_d = STATUS_OK;
    end

    // Apply the command
    pv_en_d   = pv_en_q;
    grid_en_d = grid_en_q;
    target_d  = target_q;
    case (it.cmd_kind)
      CMD_ENABLE: begin
        pv_en_d   = it.cmd_val[1];
        grid_en_d = it.cmd_val[0];
      end
      CMD_TARGET: target_d = it.cmd_val;
      default: ;
    endcase

    // PV relay
    pv_hot  = (it.temp >= cfg_i.pv_off_temp) && (prev_temp_q >= cfg_i.pv_off_temp) &&
              (prev2_temp_q >= cfg_i.pv_off_temp);
    pv_cold = (it.temp < cfg_i.pv_on_temp) && (prev_temp_q < cfg_i.pv_on_temp) &&
              (prev2_temp_q < cfg_i.pv_on_temp);
    pv_relay_d = pv_relay_q;
    seq_d      = SEQ_NONE;
    if (pv_en_d) begin
      if (pv_relay_q) begin
        if (pv_hot || (dark_d > DARK_LIMIT) || it.isol_err || it.switch_err) begin
          pv_relay_d = 1'b0;
          seq_d      = SEQ_OFF;
        end
      end else if (pv_cold && (pv_seen > cfg_i.rest_cycles) && it.pv_start_ok) begin
        pv_relay_d = 1'b1;
        seq_d      = SEQ_ON;
      end
    end else if (pv_relay_q) begin
      pv_relay_d = 1'b0;
      seq_d      = SEQ_OFF;
    end

    // Grid relay: target times ten, less hysteresis
    grid_hi   = {target_d, 3'b000} + {2'b00, target_d, 1'b0};
    grid_lo   = $signed({2'b00, grid_hi}) - $signed({5'b00000, cfg_i.grid_hysteresis});
    grid_hot  = (it.temp >= grid_hi) && (prev_temp_q >= grid_hi) && (prev2_temp_q >= grid_hi);
    grid_cold = ($signed({2'b00, it.temp}) < grid_lo) &&
                ($signed({2'b00, prev_temp_q}) < grid_lo) &&
                ($signed({2'b00, prev2_temp_q}) < grid_lo);
    grid_relay_d = grid_relay_q;
    if (grid_en_d) begin
      if (grid_relay_q) begin
        if (grid_hot || grid_err || it.switch_err || it.line_low) begin
          grid_relay_d = 1'b0;
        end
      end else if (grid_cold && (grid_seen > cfg_i.rest_cycles) && !grid_err &&
                   !it.switch_err && it.line_high) begin
        grid_relay_d = 1'b1;
      end
    end else begin
      grid_relay_d = 1'b0;
    end
  end

  // Commit state on pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_temp_q  <= PREV_TEMP_RST;
      prev2_temp_q <= PREV2_TEMP_RST;
      dark_q       <= '0;
      bad_grid_q   <= '0;
      pv_off_q     <= '0;
      grid_off_q   <= '0;
      pv_relay_q   <= 1'b0;
      grid_relay_q <= 1'b0;
      pv_en_q      <= 1'b1;
      grid_en_q    <= 1'b1;
      target_q     <= TARGET_RST;
    end else if (pop) begin
      prev_temp_q  <= it.temp;
      prev2_temp_q <= prev_temp_q;
      dark_q       <= dark_d;
      bad_grid_q   <= bad_grid_d;
      pv_off_q     <= pv_off_d;
      grid_off_q   <= grid_off_d;
      pv_relay_q   <= pv_relay_d;
      grid_relay_q <= grid_relay_d;
      pv_en_q      <= pv_en_d;
      grid_en_q    <= grid_en_d;
      target_q     <= target_d;
    end
  end

  // Output valid: set on pop, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= pop_valid_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      seq_q    <= seq_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign grid_relay_o   = grid_relay_q;
  assign pv_relay_o     = pv_relay_q;
  assign pv_sequence_o  = seq_q;
  assign status_o       = status_q;
  assign pv_enabled_o   = pv_en_q;
  assign grid_enabled_o = grid_en_q;
  assign grid_target_o  = target_q;

  `SGHRC_ASSERT_IMP(a_pv_relay_needs_enable, out_valid_q && pv_relay_q, pv_en_q,
                    "PV relay on while PV disabled")
  `SGHRC_ASSERT_IMP(a_grid_relay_needs_enable, out_valid_q && grid_relay_q, grid_en_q,
                    "grid relay on while grid disabled")
  `SGHRC_ASSERT_IMP(a_seq_on_relay_on, out_valid_q && (seq_q == SEQ_ON), pv_relay_q,
                    "PV turn-on sequence with relay off")
  `SGHRC_ASSERT_IMP(a_seq_off_relay_off, out_valid_q && (seq_q == SEQ_OFF), !pv_relay_q,
                    "PV turn-off sequence with relay on")
  `SGHRC_ASSERT_NXT(a_pop_gives_result, pop, out_valid_q,
                    "popped request produced no result")

endmodule

`default_nettype wire

### hdl/solar_grid_heater_relay_control.sv
// Solar and grid water heater relay control. One request is one control
// cycle of scaled measurements; one result follows each request. A front stage
// classifies the request against the configuration, a queue of QueueDepth
// entries decouples it from the back stage, and the back stage updates the
// relay state and registers the result. Sustained rate is one request per
// clock while the result side is not stalled, set by the state update in the
// back stage; a request passes from the front register through the queue into
// the back stage's output register, where its result waits until taken.
// Configuration writes take effect at once and must be made while idle.
// Depends on sghrc_pkg, sghrc_front, sghrc_fifo and sghrc_back.
`timescale 1ns / 1ps
`default_nettype none

module solar_grid_heater_relay_control
  import sghrc_pkg::*;
#(
  parameter int unsigned QueueDepth = SGHRC_QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Measurement requests
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  cmd_valid_i,
  input  wire logic [7:0]            cmd_byte_i,
  input  wire logic [11:0]           pv_volts_i,
  input  wire logic [11:0]           grid_volts_i,
  input  wire logic signed [11:0]    water_temp_i,
  input  wire logic [12:0]           earth_volts_i,
  input  wire logic [7:0]            line_switch_volts_i,
  input  wire logic [7:0]            neutral_switch_volts_i,
  // Results
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       grid_relay_o,
  output logic                       pv_relay_o,
  output logic [1:0]                 pv_sequence_o,
  output logic [2:0]                 status_o,
  output logic                       pv_enabled_o,
  output logic                       grid_enabled_o,
  output logic [6:0]                 grid_target_o
);

  cfg_t  cfg_q;
  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PV_OFF_TEMP:     cfg_q.pv_off_temp     <= cfg_data_i[9:0];
        CFG_PV_ON_TEMP:      cfg_q.pv_on_temp      <= cfg_data_i[9:0];
        CFG_PV_MIN_VOLTS:    cfg_q.pv_min_volts    <= cfg_data_i[11:0];
        CFG_REST_CYCLES:     cfg_q.rest_cycles     <= cfg_data_i[15:0];
        CFG_GRID_LOW_VOLTS:  cfg_q.grid_low_volts  <= cfg_data_i[11:0];
        CFG_GRID_HIGH_VOLTS: cfg_q.grid_high_volts <= cfg_data_i[11:0];
        CFG_ISOLATION_LIMIT: cfg_q.isolation_limit <= cfg_data_i[12:0];
        CFG_GRID_HYSTERESIS: cfg_q.grid_hysteresis <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  sghrc_front u_front (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg_q),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .cmd_valid_i            (cmd_valid_i),
    .cmd_byte_i             (cmd_byte_i),
    .pv_volts_i             (pv_volts_i),
    .grid_volts_i           (grid_volts_i),
    .water_temp_i           (water_temp_i),
    .earth_volts_i          (earth_volts_i),
    .line_switch_volts_i    (line_switch_volts_i),
    .neutral_switch_volts_i (neutral_switch_volts_i),
    .push_valid_o           (push_valid),
    .push_ready_i           (push_ready),
    .push_item_o            (push_item)
  );

  sghrc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  sghrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .grid_relay_o   (grid_relay_o),
    .pv_relay_o     (pv_relay_o),
    .pv_sequence_o  (pv_sequence_o),
    .status_o       (status_o),
    .pv_enabled_o   (pv_enabled_o),
    .grid_enabled_o (grid_enabled_o),
    .grid_target_o  (grid_target_o)
  );

endmodule

`default_nettype wire

### tb/solar_grid_heater_relay_control_test.sv
// Self-checking testbench for the solar and grid heater relay control block.
// Holds its own prediction of the relay decisions and drives random traffic.
// Depends on sghrc_pkg and solar_grid_heater_relay_control.
`timescale 1ns / 1ps

module solar_grid_heater_relay_control_test;
  import sghrc_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 4;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int NUM_PHASES      = 6;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES  = 200_000;
  localparam int MAX_REPORTS     = 10;

  // Enable command bytes: bit 1 enables PV, bit 0 enables grid
  localparam logic [7:0] ENABLE_NONE = 8'd0;
  localparam logic [7:0] ENABLE_GRID = 8'd1;
  localparam logic [7:0] ENABLE_PV   = 8'd2;
  localparam logic [7:0] ENABLE_BOTH = 8'd3;

  typedef struct {
    logic               cmd_valid;
    logic [7:0]         cmd_byte;
    logic [11:0]        pv_volts;
    logic [11:0]        grid_volts;
    logic signed [11:0] water_temp;
    logic [12:0]        earth_volts;
    logic [7:0]         line_switch_volts;
    logic [7:0]         neutral_switch_volts;
  } meas_t;

  typedef struct {
    logic       grid_relay;
    logic       pv_relay;
    seq_e       pv_sequence;
    status_e    status;
    logic       pv_enabled;
    logic       grid_enabled;
    logic [6:0] grid_target;
  } relay_result_t;

  // Relay decision predictor and store of expected relay states
  class relay_scoreboard;
    cfg_t          cfg;
    logic [9:0]    last_temp;
    logic [9:0]    older_temp;
    logic [2:0]    dark_cycles;
    logic [1:0]    bad_grid_cycles;
    logic [15:0]   pv_rest;
    logic [15:0]   grid_rest;
    logic          pv_on;
    logic          grid_on;
    logic          pv_en;
    logic          grid_en;
    logic [6:0]    target_degrees;
    relay_result_t expected_relay_states[$];
    int            fail_count;
    int            reported;

    function new();
      cfg             = CFG_RESET;
      last_temp       = PREV_TEMP_RST;
      older_temp      = PREV2_TEMP_RST;
      dark_cycles     = '0;
      bad_grid_cycles = '0;
      pv_rest         = '0;
      grid_rest       = '0;
      pv_on           = 1'b0;
      grid_on         = 1'b0;
      pv_en           = 1'b1;
      grid_en         = 1'b1;
      target_degrees  = TARGET_RST;
      fail_count      = 0;
      reported        = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PV_OFF_TEMP:     cfg.pv_off_temp     = val[9:0];
        CFG_PV_ON_TEMP:      cfg.pv_on_temp      = val[9:0];
        CFG_PV_MIN_VOLTS:    cfg.pv_min_volts    = val[11:0];
        CFG_REST_CYCLES:     cfg.rest_cycles     = val[15:0];
        CFG_GRID_LOW_VOLTS:  cfg.grid_low_volts  = val[11:0];
        CFG_GRID_HIGH_VOLTS: cfg.grid_high_volts = val[11:0];
        CFG_ISOLATION_LIMIT: cfg.isolation_limit = val[12:0];
        CFG_GRID_HYSTERESIS: cfg.grid_hysteresis = val[6:0];
        default: ;
      endcase
    endfunction

    // Advance the control state for one request and return the relay outputs
    function relay_result_t next_relay_state(meas_t m);
      logic [9:0]    t;
      logic          sensor_err;
      logic          grid_err;
      logic          isol_err;
      logic          switch_err;
      logic [15:0]   pv_gap;
      logic [15:0]   grid_gap;
      int            grid_hi;
      int            grid_lo;
      relay_result_t r;

      r.pv_sequence = SEQ_NONE;

      // Clamp a faulty temperature reading
      sensor_err = (m.water_temp < 12'sd0) || (m.water_temp >= 12'sd990);
      t = sensor_err ? TEMP_FAULT : m.water_temp[9:0];

      if (m.pv_volts < DARK_VOLTS) begin
        if (dark_cycles < DARK_MAX) dark_cycles++;
      end else begin
        dark_cycles = '0;
      end

      if (m.grid_volts < cfg.grid_low_volts || m.grid_volts > cfg.grid_high_volts) begin
        if (bad_grid_cycles < GRID_BAD_LIMIT) bad_grid_cycles++;
      end else begin
        bad_grid_cycles = '0;
      end
      grid_err   = (bad_grid_cycles >= GRID_BAD_LIMIT);
      isol_err   = (m.earth_volts > cfg.isolation_limit);
      switch_err = (m.neutral_switch_volts < SWITCH_ERR_VOLTS);

      // Off counts restart from zero while a relay is on
      pv_gap    = pv_on ? '0 : pv_rest;
      grid_gap  = grid_on ? '0 : grid_rest;
      pv_rest   = (pv_gap == OFF_COUNT_MAX) ? pv_gap : pv_gap + 16'd1;
      grid_rest = (grid_gap == OFF_COUNT_MAX) ? grid_gap : grid_gap + 16'd1;

      if (isol_err)        r.status = STATUS_ISOLATION;
      else if (sensor_err) r.status = STATUS_SENSOR;
      else if (switch_err) r.status = STATUS_SWITCH;
      else if (grid_err)   r.status = STATUS_GRID;
      else                 r.status = STATUS_OK;

      if (m.cmd_valid) begin
        if (m.cmd_byte <= CMD_ENABLE_MAX) begin
          pv_en   = m.cmd_byte[1];
          grid_en = m.cmd_byte[0];
        end else if (m.cmd_byte >= CMD_TARGET_MIN && m.cmd_byte <= CMD_TARGET_MAX) begin
          target_degrees = m.cmd_byte[6:0];
        end
      end

      // PV relay hysteresis over the last three temperatures
      if (pv_en) begin
        if (pv_on) begin
          if ((t >= cfg.pv_off_temp && last_temp >= cfg.pv_off_temp &&
               older_temp >= cfg.pv_off_temp) ||
              dark_cycles > DARK_LIMIT || isol_err || switch_err) begin
            pv_on = 1'b0;
            r.pv_sequence = SEQ_OFF;
          end
        end else if (t < cfg.pv_on_temp && last_temp < cfg.pv_on_temp &&
                     older_temp < cfg.pv_on_temp && pv_gap > cfg.rest_cycles &&
                     m.pv_volts > cfg.pv_min_volts && m.earth_volts < EARTH_ON_VOLTS &&
                     m.neutral_switch_volts > SWITCH_ON_VOLTS) begin
          pv_on = 1'b1;
          r.pv_sequence = SEQ_ON;
        end
      end else if (pv_on) begin
        pv_on = 1'b0;
        r.pv_sequence = SEQ_OFF;
      end

      // Grid relay hysteresis around the target
      grid_hi = int'(target_degrees) * 10;
      grid_lo = grid_hi - int'(cfg.grid_hysteresis);
      if (grid_en) begin
        if (grid_on) begin
          if ((int'(t) >= grid_hi && int'(last_temp) >= grid_hi &&
               int'(older_temp) >= grid_hi) ||
              grid_err || switch_err || m.line_switch_volts < SWITCH_ERR_VOLTS)
            grid_on = 1'b0;
        end else if (int'(t) < grid_lo && int'(last_temp) < grid_lo &&
                     int'(older_temp) < grid_lo && grid_gap > cfg.rest_cycles &&
                     !grid_err && !switch_err && m.line_switch_volts > SWITCH_ON_VOLTS) begin
          grid_on = 1'b1;
        end
      end else begin
        grid_on = 1'b0;
      end

      older_temp = last_temp;
      last_temp  = t;

      r.grid_relay   = grid_on;
      r.pv_relay     = pv_on;
      r.pv_enabled   = pv_en;
      r.grid_enabled = grid_en;
      r.grid_target  = target_degrees;
      return r;
    endfunction

    function void note_request(meas_t m);
      expected_relay_states.push_back(next_relay_state(m));
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("[%0t] %s", $time, msg);
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        note_failure($sformatf("%s: expected %0d, actual %0d", name, want, got));
    endfunction

    function void check_result(relay_result_t got);
      relay_result_t want;
      if (expected_relay_states.size() == 0) begin
        note_failure($sformatf("result with no request outstanding: grid %0b pv %0b status %0d",
                               got.grid_relay, got.pv_relay, got.status));
        return;
      end
      want = expected_relay_states.pop_front();
      check_field("grid_relay", want.grid_relay, got.grid_relay);
      check_field("pv_relay", want.pv_relay, got.pv_relay);
      check_field("pv_sequence", want.pv_sequence, got.pv_sequence);
      check_field("status", want.status, got.status);
      check_field("pv_enabled", want.pv_enabled, got.pv_enabled);
      check_field("grid_enabled", want.grid_enabled, got.grid_enabled);
      check_field("grid_target", want.grid_target, got.grid_target);
    endfunction

    function int pending_count();
      return expected_relay_states.size();
    endfunction

    function void flag_leftovers();
      foreach (expected_relay_states[i])
        note_failure($sformatf("missing result: expected grid %0b pv %0b status %0d",
                               expected_relay_states[i].grid_relay,
                               expected_relay_states[i].pv_relay,
                               expected_relay_states[i].status));
    endfunction
  endclass

  logic                  clk_i                  = 1'b0;
  logic                  rst_ni                 = 1'b0;
  logic                  cfg_we_i               = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i            = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i             = '0;
  logic                  in_valid_i             = 1'b0;
  logic                  in_ready_o;
  logic                  cmd_valid_i            = 1'b0;
  logic [7:0]            cmd_byte_i             = '0;
  logic [11:0]           pv_volts_i             = '0;
  logic [11:0]           grid_volts_i           = '0;
  logic signed [11:0]    water_temp_i           = '0;
  logic [12:0]           earth_volts_i          = '0;
  logic [7:0]            line_switch_volts_i    = '0;
  logic [7:0]            neutral_switch_volts_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i            = 1'b0;
  logic                  grid_relay_o;
  logic                  pv_relay_o;
  logic [1:0]            pv_sequence_o;
  logic [2:0]            status_o;
  logic                  pv_enabled_o;
  logic                  grid_enabled_o;
  logic [6:0]            grid_target_o;

  relay_scoreboard sb;
  int              send_idle_pct  = 20;
  int              recv_stall_pct = 67;

  // Stimulus shaping state
  int temp_walk  = 500;
  int walk_left  = 0;
  int dark_run   = 0;
  int bad_run    = 0;

  solar_grid_heater_relay_control i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .cmd_valid_i           (cmd_valid_i),
    .cmd_byte_i            (cmd_byte_i),
    .pv_volts_i            (pv_volts_i),
    .grid_volts_i          (grid_volts_i),
    .water_temp_i          (water_temp_i),
    .earth_volts_i         (earth_volts_i),
    .line_switch_volts_i   (line_switch_volts_i),
    .neutral_switch_volts_i(neutral_switch_volts_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .grid_relay_o          (grid_relay_o),
    .pv_relay_o            (pv_relay_o),
    .pv_sequence_o         (pv_sequence_o),
    .status_o              (status_o),
    .pv_enabled_o          (pv_enabled_o),
    .grid_enabled_o        (grid_enabled_o),
    .grid_target_o         (grid_target_o)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else         out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    relay_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.grid_relay   = grid_relay_o;
      got.pv_relay     = pv_relay_o;
      got.pv_sequence  = seq_e'(pv_sequence_o);
      got.status       = status_e'(status_o);
      got.pv_enabled   = pv_enabled_o;
      got.grid_enabled = grid_enabled_o;
      got.grid_target  = grid_target_o;
      sb.check_result(got);
    end
  end

  // Hold the request until accepted, with random gaps ahead of it
  task automatic send_request(meas_t m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    cmd_valid_i            <= m.cmd_valid;
    cmd_byte_i             <= m.cmd_byte;
    pv_volts_i             <= m.pv_volts;
    grid_volts_i           <= m.grid_volts;
    water_temp_i           <= m.water_temp;
    earth_volts_i          <= m.earth_volts;
    line_switch_volts_i    <= m.line_switch_volts;
    neutral_switch_volts_i <= m.neutral_switch_volts;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(m);
  endtask

  task automatic send_fields(logic cv, logic [7:0] cmd, int pv, int grid, int temp,
                             int earth, int line, int neut);
    meas_t m;
    m.cmd_valid            = cv;
    m.cmd_byte             = cmd;
    m.pv_volts             = 12'(pv);
    m.grid_volts           = 12'(grid);
    m.water_temp           = 12'(temp);
    m.earth_volts          = 13'(earth);
    m.line_switch_volts    = 8'(line);
    m.neutral_switch_volts = 8'(neut);
    send_request(m);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
  endtask

  task automatic write_one(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.write_register(idx, val);
  endtask

  task automatic apply_settings(cfg_t s);
    write_one(CFG_PV_OFF_TEMP, 16'(s.pv_off_temp));
    write_one(CFG_PV_ON_TEMP, 16'(s.pv_on_temp));
    write_one(CFG_PV_MIN_VOLTS, 16'(s.pv_min_volts));
    write_one(CFG_REST_CYCLES, s.rest_cycles);
    write_one(CFG_GRID_LOW_VOLTS, 16'(s.grid_low_volts));
    write_one(CFG_GRID_HIGH_VOLTS, 16'(s.grid_high_volts));
    write_one(CFG_ISOLATION_LIMIT, 16'(s.isolation_limit));
    write_one(CFG_GRID_HYSTERESIS, 16'(s.grid_hysteresis));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic cfg_t random_settings(int rest_max);
    cfg_t s;
    s.pv_off_temp     = 10'($urandom_range(300, 990));
    s.pv_on_temp      = 10'($urandom_range(200, s.pv_off_temp));
    s.pv_min_volts    = 12'($urandom_range(0, 2000));
    s.rest_cycles     = 16'($urandom_range(0, rest_max));
    s.grid_low_volts  = 12'($urandom_range(1000, 2300));
    s.grid_high_volts = 12'($urandom_range(s.grid_low_volts, 4000));
    s.isolation_limit = 13'($urandom_range(20, 600));
    s.grid_hysteresis = 7'($urandom_range(0, 100));
    return s;
  endfunction

  // Mostly plausible control cycles: temperature drifting across the
  // thresholds, runs of darkness and bad grid; the rest full-width noise
  task automatic build_request(output meas_t m);
    int lim;
    int sel;
    if ($urandom_range(0, 99) < 12) begin
      m.cmd_valid            = 1'($urandom);
      m.cmd_byte             = 8'($urandom);
      m.pv_volts             = 12'($urandom);
      m.grid_volts           = 12'($urandom);
      m.water_temp           = 12'($urandom);
      m.earth_volts          = 13'($urandom);
      m.line_switch_volts    = 8'($urandom);
      m.neutral_switch_volts = 8'($urandom);
      return;
    end

    // Re-center the temperature walk on one of the thresholds
    if (walk_left == 0) begin
      case ($urandom_range(0, 3))
        0:       temp_walk = int'(sb.cfg.pv_on_temp);
        1:       temp_walk = int'(sb.cfg.pv_off_temp);
        2:       temp_walk = int'(sb.target_degrees) * 10;
        default: temp_walk = int'(sb.target_degrees) * 10 - int'(sb.cfg.grid_hysteresis);
      endcase
      temp_walk += int'($urandom_range(0, 60)) - 30;
      walk_left  = $urandom_range(20, 60);
    end
    walk_left--;
    temp_walk += int'($urandom_range(0, 16)) - 8;
    if (temp_walk < 0)   temp_walk = 0;
    if (temp_walk > 989) temp_walk = 989;
    if ($urandom_range(0, 99) < 3)
      m.water_temp = $urandom_range(0, 1) ? 12'(-1 - int'($urandom_range(0, 500)))
                                          : 12'($urandom_range(990, 1500));
    else
      m.water_temp = 12'(temp_walk);

    // PV voltage with occasional dark stretches
    if (dark_run == 0 && $urandom_range(0, 99) < 3) dark_run = $urandom_range(3, 9);
    if (dark_run > 0) begin
      dark_run--;
      m.pv_volts = 12'($urandom_range(0, 19));
    end else if (sb.cfg.pv_min_volts < 12'd2300 && $urandom_range(0, 99) < 90) begin
      m.pv_volts = 12'($urandom_range(sb.cfg.pv_min_volts + 1, 2300));
    end else begin
      m.pv_volts = 12'($urandom_range(0, 2300));
    end

    // Grid voltage with occasional bad stretches
    if (bad_run == 0 && $urandom_range(0, 99) < 4) bad_run = $urandom_range(1, 5);
    if (bad_run > 0) begin
      bad_run--;
      if (sb.cfg.grid_low_volts > 0 && $urandom_range(0, 1))
        m.grid_volts = 12'($urandom_range(0, sb.cfg.grid_low_volts - 1));
      else
        m.grid_volts = 12'($urandom_range(sb.cfg.grid_high_volts + 1, 4095));
    end else if (sb.cfg.grid_low_volts <= sb.cfg.grid_high_volts) begin
      m.grid_volts = 12'($urandom_range(sb.cfg.grid_low_volts, sb.cfg.grid_high_volts));
    end else begin
      m.grid_volts = 12'($urandom_range(0, 4000));
    end

    lim = int'(sb.cfg.isolation_limit) + 200;
    if (lim > 4500) lim = 4500;
    m.earth_volts = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(0, 49))
                                                 : 13'($urandom_range(0, lim));
    m.line_switch_volts    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(41, 150))
                                                          : 8'($urandom_range(0, 150));
    m.neutral_switch_volts = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(41, 150))
                                                          : 8'($urandom_range(0, 150));

    // Occasional command, mostly keeping both enables on
    m.cmd_valid = ($urandom_range(0, 99) < 6);
    m.cmd_byte  = 8'($urandom);
    if (m.cmd_valid) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        m.cmd_byte = ($urandom_range(0, 99) < 60) ? ENABLE_BOTH : 8'($urandom_range(0, 3));
      else if (sel < 8)
        m.cmd_byte = 8'($urandom_range(CMD_TARGET_MIN, CMD_TARGET_MAX));
      else if ($urandom_range(0, 1))
        m.cmd_byte = CMD_ENABLE_MAX + 8'd1;
      else
        m.cmd_byte = 8'($urandom_range(CMD_TARGET_MAX + 1, 255));
    end
  endtask

  initial begin
    meas_t m;
    cfg_t  phase_cfg[NUM_PHASES];

    sb = new();
    phase_cfg[0] = '{10'd600, 10'd580, 12'd500, 16'd0, 12'd1750, 12'd2650, 13'd120, 7'd30};
    phase_cfg[1] = '{default: '0};
    phase_cfg[2] = '{10'd990, 10'd990, 12'd2300, 16'd65535, 12'd4000, 12'd4000,
                     13'd4500, 7'd100};
    phase_cfg[3] = random_settings(20);
    phase_cfg[4] = CFG_RESET;
    phase_cfg[4].rest_cycles = 16'd3;
    phase_cfg[5] = random_settings(200);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, commands, faults and threshold edges
    send_fields(1'b0, ENABLE_NONE, 0, 0, 0, 0, 0, 0);
    send_fields(1'b1, 8'd255, 2300, 4000, 1500, 4500, 150, 150);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, -500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, -1, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, 989, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, 990, 10, 100, 100);
    send_fields(1'b1, ENABLE_NONE, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b1, ENABLE_GRID, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b1, ENABLE_PV, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b1, ENABLE_BOTH, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b1, CMD_ENABLE_MAX + 8'd1, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b1, CMD_TARGET_MIN, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b1, CMD_TARGET_MAX + 8'd1, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b1, CMD_TARGET_MAX, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 19, 2300, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 20, 2300, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 1749, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2651, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 4000, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 1750, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2650, 500, 10, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, 500, 120, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, 500, 121, 100, 100);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, 500, 10, 9, 9);
    send_fields(1'b0, ENABLE_NONE, 1500, 2300, 500, 10, 41, 10);

    // Random phases, each under its own settings, with an idling pattern per pair of phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      apply_settings(phase_cfg[p]);
      case (p / 2)
        0:       begin send_idle_pct = 20; recv_stall_pct = 67; end
        1:       begin send_idle_pct = 67; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2) drain_results();
        build_request(m);
        send_request(m);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
